// ===== design/bpa_pkg.sv =====
`default_nettype none

package bpa_pkg;

  localparam int BLOCK_BYTES = 64;
  localparam int BLK_SHIFT   = $clog2(BLOCK_BYTES);

  localparam int OP_W   = 2;
  localparam int SIZE_W = 17;
  localparam int OFFS_W = 16;
  localparam int FREE_W = 17;
  localparam int STAT_W = 2;
  localparam int POOL_W = 11;
  localparam int NEED_W = SIZE_W - BLK_SHIFT + 1;

  localparam logic [POOL_W-1:0] POOL_RESET = 11'd1024;

  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STAT_W-1:0] ST_NO_ROOM = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [SIZE_W-1:0] size_bytes;
    logic [OFFS_W-1:0] byte_offset;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [OFFS_W-1:0] offset_out;
    logic [FREE_W-1:0] free_bytes;
  } res_t;

endpackage

`default_nettype wire

// ===== design/bpa_ram.sv =====
`default_nettype none

module bpa_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== design/bpa_ctrl.sv =====
`default_nettype none

module bpa_ctrl #(
  parameter int MAX_BLOCKS = 1024,
  parameter int TAG_BITS   = 16,
  localparam int IDX_W = $clog2(MAX_BLOCKS),
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1),
  localparam int ENT_W = TAG_BITS + 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              req_valid,
  output logic              req_ready,
  input  bpa_pkg::req_t     req,
  input  logic [CNT_W-1:0]  n_blocks,
  output logic              res_valid,
  input  logic              res_ready,
  output bpa_pkg::res_t     res,
  output logic              ram_we,
  output logic [IDX_W-1:0]  ram_waddr,
  output logic [ENT_W-1:0]  ram_wdata,
  output logic              ram_re,
  output logic [IDX_W-1:0]  ram_raddr,
  input  logic [ENT_W-1:0]  ram_rdata
);

  import bpa_pkg::*;

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_ASCAN = 8'b0000_0100,
    S_AFILL = 8'b0000_1000,
    S_FSCAN = 8'b0001_0000,
    S_QSCAN = 8'b0010_0000,
    S_DONE  = 8'b0100_0000
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    addr_r, addr_nxt;
  logic                pend_r, pend_nxt;
  logic [IDX_W-1:0]    pend_idx_r, pend_idx_nxt;
  logic [NEED_W-1:0]   run_r, run_nxt;
  logic [IDX_W-1:0]    run_start_r, run_start_nxt;
  logic [NEED_W-1:0]   need_r, need_nxt;
  logic [TAG_BITS-1:0] tag_r, tag_nxt;
  logic                first_r, first_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [TAG_BITS-1:0] next_tag_r, next_tag_nxt;
  res_t                res_r, res_nxt;

  logic [SIZE_W:0]       size_rnd;
  logic [NEED_W-1:0]     need;
  logic [OFFS_W-BLK_SHIFT-1:0] free_idx;
  logic                  blk_in_pool;
  logic                  issue;
  logic                  rd_free;
  logic [TAG_BITS-1:0]   rd_tag;
  logic [IDX_W-1:0]      start_c;

  assign size_rnd    = {1'b0, req.size_bytes} + (SIZE_W + 1)'(BLOCK_BYTES - 1);
  assign need        = size_rnd[SIZE_W -: NEED_W];
  assign free_idx    = req.byte_offset[OFFS_W-1:BLK_SHIFT];
  assign blk_in_pool = 32'(free_idx) < 32'(n_blocks);
  assign issue       = addr_r < n_blocks;
  assign rd_free     = ram_rdata[TAG_BITS];
  assign rd_tag      = ram_rdata[TAG_BITS-1:0];
  assign start_c     = (run_r == '0) ? pend_idx_r : run_start_r;

  assign req_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    pend_nxt      = 1'b0;
    pend_idx_nxt  = addr_r[IDX_W-1:0];
    run_nxt       = run_r;
    run_start_nxt = run_start_r;
    need_nxt      = need_r;
    tag_nxt       = tag_r;
    first_nxt     = first_r;
    cnt_nxt       = cnt_r;
    next_tag_nxt  = next_tag_r;
    res_nxt       = res_r;
    ram_we        = 1'b0;
    ram_waddr     = pend_idx_r;
    ram_wdata     = {1'b1, rd_tag};
    ram_re        = 1'b0;
    ram_raddr     = addr_r[IDX_W-1:0];

    unique case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = addr_r[IDX_W-1:0];
        ram_wdata = {1'b1, {TAG_BITS{1'b0}}};
        addr_nxt  = addr_r + CNT_W'(1);
        if (addr_r[IDX_W-1:0] == IDX_W'(MAX_BLOCKS - 1)) begin
          addr_nxt  = '0;
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (req_valid) begin
          res_nxt        = '0;
          res_nxt.status = ST_INVALID;
          addr_nxt       = '0;
          run_nxt        = '0;
          cnt_nxt        = '0;
          first_nxt      = 1'b1;
          unique case (req.op)
            OP_ALLOC: begin
              if (need != '0) begin
                need_nxt  = need;
                state_nxt = S_ASCAN;
              end else begin
                state_nxt = S_DONE;
              end
            end
            OP_FREE: begin
              if (req.byte_offset[BLK_SHIFT-1:0] == '0 && blk_in_pool) begin
                res_nxt.status = ST_OK;
                addr_nxt       = CNT_W'(free_idx);
                state_nxt      = S_FSCAN;
              end else begin
                state_nxt = S_DONE;
              end
            end
            OP_QUERY: state_nxt = S_QSCAN;
            default:  state_nxt = S_DONE;
          endcase
        end
      end

      S_ASCAN: begin
        if (pend_r && rd_free && (run_r + NEED_W'(1) == need_r)) begin
          run_start_nxt = start_c;
          addr_nxt      = CNT_W'(start_c);
          state_nxt     = S_AFILL;
        end else begin
          if (pend_r) begin
            if (rd_free) begin
              run_nxt       = run_r + NEED_W'(1);
              run_start_nxt = start_c;
            end else begin
              run_nxt = '0;
            end
          end
          if (issue) begin
            ram_re   = 1'b1;
            pend_nxt = 1'b1;
            addr_nxt = addr_r + CNT_W'(1);
          end else if (!pend_r) begin
            res_nxt.status = ST_NO_ROOM;
            state_nxt      = S_DONE;
          end
        end
      end

      S_AFILL: begin
        ram_we    = 1'b1;
        ram_waddr = addr_r[IDX_W-1:0];
        ram_wdata = {1'b0, next_tag_r};
        addr_nxt  = addr_r + CNT_W'(1);
        need_nxt  = need_r - NEED_W'(1);
        if (need_r == NEED_W'(1)) begin
          next_tag_nxt       = next_tag_r + TAG_BITS'(1);
          res_nxt.status     = ST_OK;
          res_nxt.offset_out = OFFS_W'({run_start_r, {BLK_SHIFT{1'b0}}});
          state_nxt          = S_DONE;
        end
      end

      S_FSCAN: begin
        if (pend_r && (rd_free || (!first_r && rd_tag != tag_r))) begin
          state_nxt = S_DONE;
        end else begin
          if (pend_r) begin
            ram_we    = 1'b1;
            first_nxt = 1'b0;
            if (first_r) begin
              tag_nxt = rd_tag;
            end
          end
          if (issue) begin
            ram_re   = 1'b1;
            pend_nxt = 1'b1;
            addr_nxt = addr_r + CNT_W'(1);
          end else if (!pend_r) begin
            state_nxt = S_DONE;
          end
        end
      end

      S_QSCAN: begin
        if (pend_r && rd_free) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
        if (issue) begin
          ram_re   = 1'b1;
          pend_nxt = 1'b1;
          addr_nxt = addr_r + CNT_W'(1);
        end else if (!pend_r) begin
          res_nxt.status     = ST_OK;
          res_nxt.free_bytes = FREE_W'({cnt_r, {BLK_SHIFT{1'b0}}});
          state_nxt          = S_DONE;
        end
      end

      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      addr_r     <= '0;
      pend_r     <= 1'b0;
      next_tag_r <= '0;
    end else begin
      state_r    <= state_nxt;
      addr_r     <= addr_nxt;
      pend_r     <= pend_nxt;
      next_tag_r <= next_tag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_idx_r  <= pend_idx_nxt;
    run_r       <= run_nxt;
    run_start_r <= run_start_nxt;
    need_r      <= need_nxt;
    tag_r       <= tag_nxt;
    first_r     <= first_nxt;
    cnt_r       <= cnt_nxt;
    res_r       <= res_nxt;
  end

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we && ram_re |-> ram_waddr != ram_raddr)
    else $error("read and write hit the same block");

  a_read_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
    ram_re |-> 32'(ram_raddr) < 32'(n_blocks))
    else $error("scan read beyond pool end");

  a_tag_only_on_fill: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_AFILL |=> $stable(next_tag_r))
    else $error("tag counter moved outside a fill");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req_valid && req_ready |=> state_r != S_IDLE)
    else $error("request accepted but sequencer stayed idle");

endmodule

`default_nettype wire

// ===== design/block_pool_allocator_unit.sv =====
// channel  | handshake            | payload
// in       | in_valid / in_ready  | in_op, in_size_bytes, in_byte_offset
// out      | out_valid / out_ready| out_status, out_offset_out, out_free_bytes
// cfg      | cfg_we               | cfg_wdata (pool_blocks)
//
// Allocate: a scan through the owner RAM read port for a free run, then one write per
//   block of the run. Query: a scan of the pool that counts its free blocks.
// Free: a scan along the run from the freed block. Bad requests finish straight away.
// After reset a clearing pass writes every RAM entry; no requests are taken during it.
// The result register lets the next request start while a result waits on out_ready.
`default_nettype none

module block_pool_allocator_unit #(
  parameter int MAX_BLOCKS = 1024,
  parameter int TAG_BITS   = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [bpa_pkg::OP_W-1:0]     in_op,
  input  logic [bpa_pkg::SIZE_W-1:0]   in_size_bytes,
  input  logic [bpa_pkg::OFFS_W-1:0]   in_byte_offset,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [bpa_pkg::STAT_W-1:0]   out_status,
  output logic [bpa_pkg::OFFS_W-1:0]   out_offset_out,
  output logic [bpa_pkg::FREE_W-1:0]   out_free_bytes,
  input  logic                         cfg_we,
  input  logic [bpa_pkg::POOL_W-1:0]   cfg_wdata
);

  import bpa_pkg::*;

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int ENT_W = TAG_BITS + 1;

  logic [POOL_W-1:0] pool_blocks_r, pool_blocks_nxt;
  logic [CNT_W-1:0]  n_blocks;
  logic              out_valid_r, out_valid_nxt;
  res_t              out_r;
  req_t              req;
  res_t              res;
  logic              res_valid, res_ready;
  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  logic [ENT_W-1:0]  ram_wdata, ram_rdata;

  assign pool_blocks_nxt = cfg_we ? cfg_wdata : pool_blocks_r;

  always_comb begin
    if (pool_blocks_r == '0) begin
      n_blocks = CNT_W'(1);
    end else if (32'(pool_blocks_r) > MAX_BLOCKS) begin
      n_blocks = CNT_W'(MAX_BLOCKS);
    end else begin
      n_blocks = CNT_W'(pool_blocks_r);
    end
  end

  assign req.op          = in_op;
  assign req.size_bytes  = in_size_bytes;
  assign req.byte_offset = in_byte_offset;

  assign res_ready     = !out_valid_r || out_ready;
  assign out_valid_nxt = (res_valid && res_ready) || (out_valid_r && !out_ready);

  bpa_ctrl #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .TAG_BITS   (TAG_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_valid),
    .req_ready (in_ready),
    .req       (req),
    .n_blocks  (n_blocks),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  bpa_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_BLOCKS)
  ) u_owner_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_blocks_r <= POOL_RESET;
      out_valid_r   <= 1'b0;
    end else begin
      pool_blocks_r <= pool_blocks_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_r.status;
  assign out_offset_out = out_r.offset_out;
  assign out_free_bytes = out_r.free_bytes;

endmodule

`default_nettype wire
